// File: sv/pram_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pram_pkg: shared types and codes of the priority reservation manager
// Holds the list entry, the row command and row status structs, and the
// opcode, notice kind and status codes used by the cells, rows and top level.
// ----------------------------------------------------------------------------
package pram_pkg;

  localparam int unsigned SUBRESOURCES_DEF = 8;
  localparam int unsigned LIST_DEPTH_DEF   = 8;
  localparam int unsigned MASK_BITS        = 8;

  // opcodes
  localparam logic [2:0] OP_RESERVE  = 3'd0;
  localparam logic [2:0] OP_RELEASE  = 3'd1;
  localparam logic [2:0] OP_CONFLICT = 3'd2;
  localparam logic [2:0] OP_ACTIVE   = 3'd3;
  localparam logic [2:0] OP_EMPTY    = 3'd4;
  localparam logic [2:0] OP_HOLDER   = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_SUSPEND  = 2'd0;
  localparam logic [1:0] KIND_RESUME   = 2'd1;
  localparam logic [1:0] KIND_ACTIVATE = 2'd2;
  localparam logic [1:0] KIND_FINAL    = 2'd3;

  // final status
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_DENIED = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [7:0] client;
    logic [7:0] prio;
  } pram_entry_t;

  typedef struct packed {
    logic       ins;
    logic       del;
    logic [7:0] client;
    logic [7:0] prio;
  } pram_cmd_t;

  typedef struct packed {
    logic       head_valid;
    logic [7:0] head_client;
    logic [7:0] head_prio;
    logic       second_valid;
    logic [7:0] second_client;
    logic       full;
    logic       holds;
  } pram_row_stat_t;

endpackage

// File: sv/pram_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pram_cell: one entry of a holder list
// Keeps, takes the new entry, or takes a neighbor's entry, so that a row of
// cells inserts in priority order and removes a client.
// ----------------------------------------------------------------------------
module pram_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pram_pkg::pram_cmd_t   cmd_i,
  input  pram_pkg::pram_entry_t left_i,
  input  logic                  left_stay_i,
  input  logic                  left_hit_i,
  input  pram_pkg::pram_entry_t right_i,
  output pram_pkg::pram_entry_t ent_o,
  output logic                  stay_o,
  output logic                  hit_o
);
  import pram_pkg::*;

  logic        valid_q;
  logic [7:0]  client_q, prio_q;
  pram_entry_t cur, ent_d;
  logic        match;

  // assemble the held entry
  assign cur = '{valid: valid_q, client: client_q, prio: prio_q};

  // local compare against the broadcast command
  assign match  = cur.valid && (cur.client == cmd_i.client);
  assign stay_o = cur.valid && (cur.prio <= cmd_i.prio);
  assign hit_o  = left_hit_i | match;
  assign ent_o  = cur;

  // pick the next entry: hold, take new, shift right on insert, shift left on removal
  always_comb begin
    ent_d = cur;
    if (cmd_i.ins) begin
      if (!stay_o) begin
        if (left_stay_i) begin
          ent_d = '{valid: 1'b1, client: cmd_i.client, prio: cmd_i.prio};
        end else begin
          ent_d = left_i;
        end
      end
    end else if (cmd_i.del) begin
      if (hit_o) begin
        ent_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ent_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    client_q <= ent_d.client;
    prio_q   <= ent_d.prio;
  end

endmodule

// File: sv/pram_row.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pram_row: holder list of one subresource
// Chains LIST_DEPTH cells head first and reports head, second entry,
// fullness and whether the commanded client is listed.
// ----------------------------------------------------------------------------
module pram_row #(
  parameter int unsigned LIST_DEPTH = pram_pkg::LIST_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pram_pkg::pram_cmd_t      cmd_i,
  output pram_pkg::pram_row_stat_t stat_o
);
  import pram_pkg::*;

  pram_entry_t ent  [LIST_DEPTH];
  logic        stay [LIST_DEPTH];
  logic        hit  [LIST_DEPTH];

  // chain the cells, head at position zero
  for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
    pram_entry_t left_ent, right_ent;
    logic        left_stay, left_hit;

    if (k == 0) begin : g_head
      assign left_ent  = '0;
      assign left_stay = 1'b1;
      assign left_hit  = 1'b0;
    end else begin : g_body
      assign left_ent  = ent[k-1];
      assign left_stay = stay[k-1];
      assign left_hit  = hit[k-1];
    end

    if (k == LIST_DEPTH - 1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_mid
      assign right_ent = ent[k+1];
    end

    pram_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd_i),
      .left_i      (left_ent),
      .left_stay_i (left_stay),
      .left_hit_i  (left_hit),
      .right_i     (right_ent),
      .ent_o       (ent[k]),
      .stay_o      (stay[k]),
      .hit_o       (hit[k])
    );
  end

  // report the row
  assign stat_o.head_valid    = ent[0].valid;
  assign stat_o.head_client   = ent[0].client;
  assign stat_o.head_prio     = ent[0].prio;
  assign stat_o.second_valid  = ent[1].valid;
  assign stat_o.second_client = ent[1].client;
  assign stat_o.full          = ent[LIST_DEPTH-1].valid;
  assign stat_o.holds         = hit[LIST_DEPTH-1];

endmodule

// File: sv/priority_reservation_manager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_reservation_manager: priority-ordered reservation of subresources
// Top level: sequencer over one row of list cells per subresource.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with the request fields while busy is low; the item is taken
//   at that edge and busy stays high until the final result is shown.
//   Results appear on the result ports for one cycle each, marked by
//   res_valid_o: notices first in increasing subresource order, then one
//   final result with last_o high. The receiver cannot stall the results.
//   The sequencer visits one subresource per cycle. A reserve makes up to
//   two passes (a fullness pass, then an insert pass); release, conflict
//   query and active update make one pass, the other requests none, where a
//   pass visits each of the n managed subresources. Every cell of a list
//   shifts at once, so the list depth does not lengthen a pass.
//   The single configuration register (subresources in use) is written over
//   the cfg channel while busy is low.
//   Reset empties every list, sets the active mask to all ones and the
//   register to eight. No clearing pass is needed.
// ----------------------------------------------------------------------------
module priority_reservation_manager #(
  parameter int unsigned SUBRESOURCES = pram_pkg::SUBRESOURCES_DEF,
  parameter int unsigned LIST_DEPTH   = pram_pkg::LIST_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] opcode_i,
  input  logic [7:0] client_id_i,
  input  logic [7:0] priority_req_i,
  input  logic       trusted_i,
  input  logic       force_no_ui_env_i,
  input  logic [7:0] sub_mask_i,
  input  logic       all_subresources_i,
  input  logic [7:0] original_mask_i,
  input  logic [7:0] modified_mask_i,
  input  logic [2:0] target_index_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] cfg_data_i,
  output logic       res_valid_o,
  output logic [1:0] kind_o,
  output logic [7:0] notice_client_o,
  output logic [2:0] notice_index_o,
  output logic       activate_o,
  output logic [7:0] result_mask_o,
  output logic       flag_o,
  output logic [1:0] status_o,
  output logic       last_o
);
  import pram_pkg::*;

  localparam int unsigned IW  = (SUBRESOURCES > 1) ? $clog2(SUBRESOURCES) : 1;
  localparam int unsigned NW0 = $clog2(SUBRESOURCES + 1);
  localparam int unsigned NW  = (NW0 > 4) ? NW0 : 4;
  localparam int unsigned MB  = (SUBRESOURCES < MASK_BITS) ? SUBRESOURCES : MASK_BITS;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_FINAL = 4'b1000
  } pram_state_e;

  pram_state_e st_q, st_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [3:0]    cfg_q;
  logic [7:0]    active_q, active_d;
  logic [7:0]    diff_q, diff_d;
  logic [7:0]    acc_q, acc_d;
  logic          flag_q, flag_d;
  logic [1:0]    stat_q, stat_d;

  // latched request
  logic [2:0] op_q;
  logic [7:0] client_q, prio_q, smask_q;
  logic       all_q;
  logic [2:0] tidx_q;

  // result register
  logic       rv_q, rv_d;
  logic [1:0] kind_q, kind_d;
  logic [7:0] nc_q, nc_d;
  logic [2:0] ni_q, ni_d;
  logic       act_q, act_d;
  logic [7:0] rm_q, rm_d;
  logic       rf_q, rf_d;
  logic [1:0] rs_q, rs_d;
  logic       rl_q, rl_d;

  pram_cmd_t      cmd [SUBRESOURCES];
  pram_row_stat_t stat [SUBRESOURCES];
  pram_row_stat_t sel;
  logic           ins_en, del_en;

  logic [NW-1:0] n;
  logic [7:0]    idx8;
  logic          idx_last, addr, accept;
  logic [7:0]    new_active, empty_mask;
  logic          holder_flag;
  logic [7:0]    holder_client;

  assign accept      = start && !busy;
  assign busy        = (st_q != ST_IDLE);
  assign cfg_ready_o = !busy;

  // managed count and walk position
  assign n = (NW'(cfg_q) > NW'(SUBRESOURCES)) ? NW'(SUBRESOURCES) : NW'(cfg_q);
  assign idx8     = 8'(idx_q);
  assign idx_last = ((NW'(idx_q) + NW'(1)) == n);
  assign addr     = all_q || (idx8 < 8'(MASK_BITS) && smask_q[idx8[2:0]]);
  assign sel      = stat[idx_q];
  assign new_active = (active_q | modified_mask_i) & ~(original_mask_i & ~modified_mask_i);

  // one row of cells per subresource
  for (genvar r = 0; r < SUBRESOURCES; r++) begin : g_row
    assign cmd[r].ins    = ins_en && (idx_q == IW'(r));
    assign cmd[r].del    = del_en && (idx_q == IW'(r));
    assign cmd[r].client = client_q;
    assign cmd[r].prio   = prio_q;

    pram_row #(.LIST_DEPTH(LIST_DEPTH)) u_row (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd[r]),
      .stat_o (stat[r])
    );
  end

  // empty mask and holder lookup over the managed rows
  always_comb begin
    empty_mask    = '0;
    holder_flag   = 1'b0;
    holder_client = '0;
    for (int r = 0; r < MB; r++) begin
      if (NW'(r) < n && !stat[r].head_valid) begin
        empty_mask[r] = 1'b1;
      end
      if (NW'(r) < n && 3'(r) == tidx_q && stat[r].head_valid) begin
        holder_flag   = 1'b1;
        holder_client = stat[r].head_client;
      end
    end
  end

  // sequencer
  always_comb begin
    st_d     = st_q;
    idx_d    = idx_q;
    active_d = active_q;
    diff_d   = diff_q;
    acc_d    = acc_q;
    flag_d   = flag_q;
    stat_d   = stat_q;
    ins_en   = 1'b0;
    del_en   = 1'b0;
    rv_d     = 1'b0;
    kind_d   = kind_q;
    nc_d     = '0;
    ni_d     = '0;
    act_d    = 1'b0;
    rm_d     = '0;
    rf_d     = 1'b0;
    rs_d     = STAT_OK;
    rl_d     = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d  = '0;
          acc_d  = '0;
          flag_d = 1'b0;
          stat_d = STAT_OK;
          st_d   = ST_FINAL;
          case (opcode_i)
            OP_RESERVE: begin
              if (force_no_ui_env_i && !trusted_i) begin
                stat_d = STAT_DENIED;
              end else if (n != '0) begin
                st_d = ST_CHECK;
              end
            end
            OP_RELEASE, OP_CONFLICT: begin
              if (n != '0) st_d = ST_WALK;
            end
            OP_ACTIVE: begin
              active_d = new_active;
              diff_d   = active_q ^ new_active;
              if (n != '0) st_d = ST_WALK;
            end
            default: begin
              st_d = ST_FINAL;
            end
          endcase
        end
      end
      ST_CHECK: begin
        // refuse the whole reserve if a list needing an entry is full
        if (addr && !sel.holds && sel.full) begin
          stat_d = STAT_FULL;
          st_d   = ST_FINAL;
        end else if (idx_last) begin
          idx_d = '0;
          st_d  = ST_WALK;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      ST_WALK: begin
        kind_d = KIND_SUSPEND;
        case (op_q)
          OP_RESERVE: begin
            if (addr && !sel.holds) begin
              ins_en = 1'b1;
              if (sel.head_valid && sel.head_prio <= prio_q) begin
                if (idx8 < 8'(MASK_BITS)) acc_d[idx8[2:0]] = 1'b1;
              end else if (sel.head_valid) begin
                rv_d   = 1'b1;
                kind_d = KIND_SUSPEND;
                nc_d   = sel.head_client;
                ni_d   = idx8[2:0];
              end
            end
          end
          OP_RELEASE: begin
            if (addr && sel.holds) begin
              del_en = 1'b1;
              if (sel.head_client == client_q && sel.second_valid) begin
                rv_d   = 1'b1;
                kind_d = KIND_RESUME;
                nc_d   = sel.second_client;
                ni_d   = idx8[2:0];
              end
            end
          end
          OP_CONFLICT: begin
            if (addr && sel.head_valid && sel.head_client != client_q) flag_d = 1'b1;
          end
          OP_ACTIVE: begin
            if (idx8 < 8'(MASK_BITS) && diff_q[idx8[2:0]] && sel.head_valid &&
                (sel.head_client != client_q || !active_q[idx8[2:0]])) begin
              rv_d   = 1'b1;
              kind_d = KIND_ACTIVATE;
              nc_d   = sel.head_client;
              ni_d   = idx8[2:0];
              act_d  = active_q[idx8[2:0]];
            end
          end
          default: begin
            rv_d = 1'b0;
          end
        endcase
        if (idx_last) begin
          st_d = ST_FINAL;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      ST_FINAL: begin
        // emit the closing result
        rv_d   = 1'b1;
        kind_d = KIND_FINAL;
        rl_d   = 1'b1;
        case (op_q)
          OP_RESERVE: begin
            rs_d = stat_q;
            rm_d = (stat_q == STAT_OK) ? acc_q : 8'd0;
          end
          OP_RELEASE, OP_EMPTY: rm_d = empty_mask;
          OP_CONFLICT:          rf_d = flag_q;
          OP_ACTIVE:            rm_d = active_q;
          OP_HOLDER: begin
            rf_d = holder_flag;
            nc_d = holder_client;
          end
          default: rm_d = '0;
        endcase
        st_d = ST_IDLE;
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      cfg_q    <= 4'd8;
      active_q <= 8'hFF;
      rv_q     <= 1'b0;
    end else begin
      st_q     <= st_d;
      active_q <= active_d;
      rv_q     <= rv_d;
      if (cfg_valid_i && cfg_ready_o) cfg_q <= cfg_data_i;
    end
  end

  // walk state, latched request and result payload
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    diff_q <= diff_d;
    acc_q  <= acc_d;
    flag_q <= flag_d;
    stat_q <= stat_d;
    kind_q <= kind_d;
    nc_q   <= nc_d;
    ni_q   <= ni_d;
    act_q  <= act_d;
    rm_q   <= rm_d;
    rf_q   <= rf_d;
    rs_q   <= rs_d;
    rl_q   <= rl_d;
    if (accept) begin
      op_q     <= opcode_i;
      client_q <= client_id_i;
      prio_q   <= priority_req_i;
      smask_q  <= sub_mask_i;
      all_q    <= all_subresources_i;
      tidx_q   <= target_index_i;
    end
  end

  assign res_valid_o     = rv_q;
  assign kind_o          = kind_q;
  assign notice_client_o = nc_q;
  assign notice_index_o  = ni_q;
  assign activate_o      = act_q;
  assign result_mask_o   = rm_q;
  assign flag_o          = rf_q;
  assign status_o        = rs_q;
  assign last_o          = rl_q;

`ifndef SYNTHESIS
  a_done_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res_valid_o && last_o)
    else $error("busy dropped without a final result");
  a_final_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && last_o |-> !busy && kind_o == KIND_FINAL)
    else $error("final result shown while busy or with wrong kind");
  a_notice_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !last_o |-> busy && kind_o != KIND_FINAL)
    else $error("notice outside a running item");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");
`endif

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the priority reservation manager
// Drives reserve, release, query and active-update requests with random gaps,
// predicts every notice and final result, and compares them in order.
// The subresource count register is changed between phases.
// ----------------------------------------------------------------------------
module testbench;
  import pram_pkg::*;

  localparam logic [2:0] OP_UNDEF_LO = 3'd6;
  localparam logic [2:0] OP_UNDEF_HI = 3'd7;
  localparam int         DEPTH       = 8;
  localparam int         SUBS        = 8;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] client;
    logic [7:0] prio;
    logic       trusted;
    logic       force_no_ui;
    logic [7:0] sub_mask;
    logic       all_subs;
    logic [7:0] orig_mask;
    logic [7:0] mod_mask;
    logic [2:0] target;
  } request_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] client;
    logic [2:0] index;
    logic       act;
    logic [7:0] mask;
    logic       flag;
    logic [1:0] status;
    logic       last;
  } outcome_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [3:0] cfg_data_i = '0;
  request_t   req = '0;
  outcome_t   got;
  logic       res_valid_o;

  // shadow state of the lists, counts, active mask and register
  logic [7:0] row_client [SUBS][DEPTH];
  logic [7:0] row_prio   [SUBS][DEPTH];
  int         row_count  [SUBS];
  logic [7:0] active_bits;
  int         subs_in_use;

  outcome_t   pending_outcomes[$];
  int         mismatches = 0;
  int         items_sent = 0;
  int         outcomes_seen = 0;
  bit         no_idle = 0;

  always #1 clk_i = ~clk_i;

  priority_reservation_manager DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .opcode_i           (req.opcode),
    .client_id_i        (req.client),
    .priority_req_i     (req.prio),
    .trusted_i          (req.trusted),
    .force_no_ui_env_i  (req.force_no_ui),
    .sub_mask_i         (req.sub_mask),
    .all_subresources_i (req.all_subs),
    .original_mask_i    (req.orig_mask),
    .modified_mask_i    (req.mod_mask),
    .target_index_i     (req.target),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .res_valid_o        (res_valid_o),
    .kind_o             (got.kind),
    .notice_client_o    (got.client),
    .notice_index_o     (got.index),
    .activate_o         (got.act),
    .result_mask_o      (got.mask),
    .flag_o             (got.flag),
    .status_o           (got.status),
    .last_o             (got.last)
  );

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // compare each strobed result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      outcomes_seen++;
      if (pending_outcomes.size() == 0) begin
        report($sformatf("unexpected result %p", got));
      end else begin
        outcome_t want;
        want = pending_outcomes.pop_front();
        if (got !== want) report($sformatf("got %p want %p", got, want));
      end
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic int managed_count();
    return (subs_in_use > SUBS) ? SUBS : subs_in_use;
  endfunction

  function automatic int find_in_row(input int i, input logic [7:0] c);
    for (int k = 0; k < row_count[i]; k++) if (row_client[i][k] == c) return k;
    return -1;
  endfunction

  function automatic logic [7:0] empty_rows(input int n);
    logic [7:0] m;
    m = '0;
    for (int i = 0; i < n; i++) if (row_count[i] == 0) m[i] = 1'b1;
    return m;
  endfunction

  task automatic push_notice(input logic [1:0] kind, input logic [7:0] c, input int i,
                             input logic act);
    outcome_t o;
    o = '0;
    o.kind = kind; o.client = c; o.index = i[2:0]; o.act = act;
    pending_outcomes.push_back(o);
  endtask

  task automatic push_result(input logic [7:0] c, input logic [7:0] m, input logic f,
                             input logic [1:0] st);
    outcome_t o;
    o = '0;
    o.kind = KIND_FINAL; o.client = c; o.mask = m; o.flag = f; o.status = st;
    o.last = 1'b1;
    pending_outcomes.push_back(o);
  endtask

  task automatic predict_outcomes(input request_t r);
    int         n, c, pos, p;
    logic       refused, flg;
    logic [7:0] susp, nm, diff;
    logic [7:0] hit;
    n = managed_count();
    hit = '0;
    for (int i = 0; i < n; i++) hit[i] = r.all_subs | r.sub_mask[i];
    case (r.opcode)
      OP_RESERVE: begin
        if (r.force_no_ui && !r.trusted) begin
          push_result(8'd0, 8'd0, 1'b0, STAT_DENIED);
        end else begin
          refused = 1'b0;
          for (int i = 0; i < n; i++)
            if (hit[i] && find_in_row(i, r.client) < 0 && row_count[i] >= DEPTH)
              refused = 1'b1;
          if (refused) begin
            push_result(8'd0, 8'd0, 1'b0, STAT_FULL);
          end else begin
            susp = '0;
            for (int i = 0; i < n; i++) begin
              if (!hit[i] || find_in_row(i, r.client) >= 0) continue;
              c = row_count[i];
              if (c > 0 && row_prio[i][0] <= r.prio) begin
                susp[i] = 1'b1;
                pos = 1;
                while (pos < c && row_prio[i][pos] <= r.prio) pos++;
              end else begin
                pos = 0;
                if (c > 0) push_notice(KIND_SUSPEND, row_client[i][0], i, 1'b0);
              end
              for (int k = c; k > pos; k--) begin
                row_client[i][k] = row_client[i][k-1];
                row_prio[i][k]   = row_prio[i][k-1];
              end
              row_client[i][pos] = r.client;
              row_prio[i][pos]   = r.prio;
              row_count[i]       = c + 1;
            end
            push_result(8'd0, susp, 1'b0, STAT_OK);
          end
        end
      end
      OP_RELEASE: begin
        for (int i = 0; i < n; i++) begin
          if (!hit[i]) continue;
          p = find_in_row(i, r.client);
          if (p < 0) continue;
          c = row_count[i];
          for (int k = p; k + 1 < c; k++) begin
            row_client[i][k] = row_client[i][k+1];
            row_prio[i][k]   = row_prio[i][k+1];
          end
          row_count[i] = c - 1;
          if (p == 0 && c > 1) push_notice(KIND_RESUME, row_client[i][0], i, 1'b0);
        end
        push_result(8'd0, empty_rows(n), 1'b0, STAT_OK);
      end
      OP_CONFLICT: begin
        flg = 1'b0;
        for (int i = 0; i < n; i++)
          if (hit[i] && row_count[i] > 0 && row_client[i][0] != r.client) flg = 1'b1;
        push_result(8'd0, 8'd0, flg, STAT_OK);
      end
      OP_ACTIVE: begin
        nm = (active_bits | r.mod_mask) & ~(r.orig_mask & ~r.mod_mask);
        diff = active_bits ^ nm;
        active_bits = nm;
        for (int i = 0; i < n; i++)
          if (diff[i] && row_count[i] > 0 && (row_client[i][0] != r.client || !nm[i]))
            push_notice(KIND_ACTIVATE, row_client[i][0], i, nm[i]);
        push_result(8'd0, nm, 1'b0, STAT_OK);
      end
      OP_EMPTY: push_result(8'd0, empty_rows(n), 1'b0, STAT_OK);
      OP_HOLDER: begin
        if (r.target < n && row_count[r.target] > 0)
          push_result(row_client[r.target][0], 8'd0, 1'b1, STAT_OK);
        else
          push_result(8'd0, 8'd0, 1'b0, STAT_OK);
      end
      default: push_result(8'd0, 8'd0, 1'b0, STAT_OK);
    endcase
  endtask

  // ---------------------------------------------------------------- driving
  // hold start high across back-to-back items, lower it only before a gap
  task automatic send_item(input request_t r);
    int gap;
    gap = no_idle ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req   <= r;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    predict_outcomes(r);
    items_sent++;
  endtask

  // drop start and wait for every expected result
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_subs(input logic [3:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    subs_in_use = v;
  endtask

  function automatic request_t mk(input logic [2:0] op, input logic [7:0] c,
                                  input logic [7:0] p, input logic [7:0] m);
    request_t r;
    r = '0;
    r.opcode = op; r.client = c; r.prio = p; r.sub_mask = m; r.trusted = 1'b1;
    return r;
  endfunction

  // mostly well-formed traffic from a small client pool, with some noise
  function automatic request_t random_request();
    request_t r;
    int       sel;
    r.client      = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 11));
    sel           = $urandom_range(0, 3);
    r.prio        = (sel == 0) ? 8'($urandom) : (sel == 1) ? 8'hFF : 8'($urandom_range(0, 3));
    r.trusted     = ($urandom_range(0, 4) != 0);
    r.force_no_ui = ($urandom_range(0, 5) == 0);
    r.sub_mask    = 8'($urandom);
    r.all_subs    = ($urandom_range(0, 6) == 0);
    r.orig_mask   = 8'($urandom);
    r.mod_mask    = 8'($urandom);
    r.target      = 3'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 40)      r.opcode = OP_RESERVE;
    else if (sel < 65) r.opcode = OP_RELEASE;
    else if (sel < 73) r.opcode = OP_CONFLICT;
    else if (sel < 81) r.opcode = OP_ACTIVE;
    else if (sel < 87) r.opcode = OP_EMPTY;
    else if (sel < 97) r.opcode = OP_HOLDER;
    else               r.opcode = 3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
    return r;
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    request_t r;
    send_item(mk(OP_EMPTY, 8'd0, 8'd0, 8'd0));
    send_item(mk(OP_RESERVE, 8'd1, 8'd5, 8'h0F));
    send_item(mk(OP_RESERVE, 8'd2, 8'd5, 8'h03));   // equal priority queues behind
    send_item(mk(OP_RESERVE, 8'd3, 8'd0, 8'h01));   // stronger takes the head
    send_item(mk(OP_RESERVE, 8'd1, 8'd0, 8'hFF));   // already held rows are skipped
    r = mk(OP_RESERVE, 8'hFF, 8'hFF, 8'h00);
    r.force_no_ui = 1'b1; r.trusted = 1'b0;         // untrusted forced reserve
    send_item(r);
    send_item(mk(OP_CONFLICT, 8'd3, 8'd0, 8'h03));
    send_item(mk(OP_HOLDER, 8'd0, 8'd0, 8'd0));
    r = mk(OP_HOLDER, 8'd0, 8'd0, 8'd0); r.target = 3'd7;
    send_item(r);
    send_item(mk(OP_RELEASE, 8'd3, 8'd0, 8'hFF));   // resume to the next head
    send_item(mk(OP_RELEASE, 8'd99, 8'd0, 8'hFF));  // client not listed
    r = mk(OP_ACTIVE, 8'd1, 8'd0, 8'd0); r.orig_mask = 8'hFF; r.mod_mask = 8'h00;
    send_item(r);
    r = mk(OP_ACTIVE, 8'd1, 8'd0, 8'd0); r.orig_mask = 8'h00; r.mod_mask = 8'hFF;
    send_item(r);
    send_item(mk(OP_UNDEF_LO, 8'hFF, 8'hFF, 8'hFF));
    send_item(mk(OP_UNDEF_HI, 8'd0, 8'd0, 8'd0));
    // fill row 7 behind client 1 and refuse the clients beyond its depth of eight
    for (int c = 10; c < 19; c++) send_item(mk(OP_RESERVE, 8'(c), 8'(c), 8'h80));
    r = mk(OP_RELEASE, 8'd0, 8'd0, 8'd0); r.all_subs = 1'b1;
    for (int c = 10; c < 18; c++) begin r.client = 8'(c); send_item(r); end
  endtask

  task automatic test_subresource_count();
    logic [3:0] vals[5] = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd8};
    foreach (vals[v]) begin
      write_subs(vals[v]);
      for (int k = 0; k < 12; k++) send_item(random_request());
    end
  endtask

  task automatic test_random_traffic();
    for (int k = 0; k < 400; k++) begin
      if (k % 50 == 0) no_idle = ($urandom_range(0, 2) == 0);
      if (k == 200) drain();                         // sender waits for all results
      send_item(random_request());
    end
    no_idle = 0;
  endtask

  initial begin
    for (int i = 0; i < SUBS; i++) row_count[i] = 0;
    active_bits = 8'hFF;
    subs_in_use = 8;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_subresource_count();
    test_random_traffic();
    drain();
    repeat (20) @(posedge clk_i);
    if (pending_outcomes.size() != 0)
      report($sformatf("%0d results never arrived", pending_outcomes.size()));
    $display("Covered %0d requests over all opcodes, %0d results checked,", items_sent,
             outcomes_seen);
    $display("subresource counts 0, 1, 3, 8 and 15, full rows and active updates.");
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // hard stop
  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
